// ===== rtl/ldl_pkg.sv =====
// shared types, constants and helpers for the led current derating limiter
`timescale 1ns / 1ps
`default_nettype none
package ldl_pkg;

  // field widths
  localparam int TEMP_W   = 15;
  localparam int VOLT_W   = 15;
  localparam int TGT_W    = 8;
  localparam int REASON_W = 2;
  localparam int CNT_W    = 2;
  localparam int TACC_W   = 24;
  localparam int VACC_W   = 26;

  // port widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd2;

  // reset values of the registers
  localparam logic [CNT_W-1:0] CELL_COUNT_RESET = 2'd1;
  localparam logic [TGT_W-1:0] LIMIT_RESET      = 8'd216;

  // derating thresholds
  localparam logic [VOLT_W-1:0] V_CELL_MIN   = 15'd3097;
  localparam logic [VOLT_W-1:0] V_CELL_MAX   = 15'd4352;
  localparam logic [VOLT_W-1:0] V_FLAT_LO    = 15'd3223;
  localparam logic [VOLT_W-1:0] V_FLAT_HI    = 15'd3477;
  localparam logic [TEMP_W-1:0] T_MAX        = 15'd5568;
  localparam logic [TEMP_W-1:0] T_KNEE       = 15'd5312;
  localparam logic [TGT_W-1:0]  DESIGN_3CELL = 8'd204;
  localparam logic [TGT_W-1:0]  DESIGN_FULL  = 8'd255;
  localparam logic [TGT_W-1:0]  VLIM_FLOOR   = 8'd2;
  localparam logic [TGT_W-1:0]  VLIM_MID     = 8'd128;

  // reciprocal of three, exact for every 15 bit dividend
  localparam int               DIV3_SHIFT = 17;
  localparam logic [15:0]      DIV3_MULT  = 16'd43691;

  // limit reason codes
  localparam logic [REASON_W-1:0] RSN_NONE    = 2'd0;
  localparam logic [REASON_W-1:0] RSN_CURRENT = 2'd1;
  localparam logic [REASON_W-1:0] RSN_VOLTAGE = 2'd2;
  localparam logic [REASON_W-1:0] RSN_TEMP    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic filt;
    logic div;
    logic load_out;
  } ldl_cmd_t;

  typedef struct packed {
    logic [TGT_W-1:0]    drive;
    logic [REASON_W-1:0] reason;
  } ldl_beam_t;

  // clamp a target by current, voltage and temperature limits in turn
  function automatic ldl_beam_t limit_beam(input logic [TGT_W-1:0] target,
                                           input logic [TGT_W-1:0] cur,
                                           input logic [TGT_W-1:0] vlim,
                                           input logic [TGT_W-1:0] tlim);
    ldl_beam_t res;
    res.drive  = target;
    res.reason = RSN_NONE;
    if (res.drive > cur) begin
      res.drive  = cur;
      res.reason = RSN_CURRENT;
    end
    if (res.drive > vlim) begin
      res.drive  = vlim;
      res.reason = RSN_VOLTAGE;
    end
    if (res.drive > tlim) begin
      res.drive  = tlim;
      res.reason = RSN_TEMP;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ldl_ctrl.sv =====
// sequencing controller for the led current derating limiter
`timescale 1ns / 1ps
`default_nettype none
module ldl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output ldl_pkg::ldl_cmd_t    cmd
);
  import ldl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_LIM  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // output register can take a new beat
  assign out_free = !out_valid_r || out_tready;

  // commands
  always_comb begin
    cmd.load_in  = (state_r == ST_IDLE) && in_tvalid;
    cmd.filt     = (state_r == ST_FILT);
    cmd.div      = (state_r == ST_DIV);
    cmd.load_out = (state_r == ST_LIM) && out_free;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_FILT;
      ST_FILT: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_LIM;
      ST_LIM:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ldl_dpath.sv =====
// filters, per-cell division and limit datapath for the led current derating limiter
`timescale 1ns / 1ps
`default_nettype none
module ldl_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ldl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ldl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [ldl_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tuser,
  input  wire ldl_pkg::ldl_cmd_t                 cmd,
  output logic [ldl_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import ldl_pkg::*;

  // configuration registers
  logic [CNT_W-1:0] cell_count_r;
  logic [TGT_W-1:0] main_limit_r;
  logic [TGT_W-1:0] high_limit_r;

  // captured input beat
  logic [TEMP_W-1:0] rt_r;
  logic [VOLT_W-1:0] rv_r;
  logic [TGT_W-1:0]  mt_r;
  logic [TGT_W-1:0]  ht_r;
  logic              act_r;

  // filter state and results
  logic        [TACC_W-1:0] tacc_r, tacc_nxt;
  logic signed [VACC_W-1:0] vacc_r, vacc_nxt;
  logic        [TEMP_W-1:0] ft_r, ft_nxt;
  logic        [VOLT_W-1:0] fv_r, fv_nxt;
  logic        [VOLT_W-1:0] n_r, n_nxt;

  // output payload
  logic [OUT_TDATA_W-1:0] out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= CELL_COUNT_RESET;
      main_limit_r <= LIMIT_RESET;
      high_limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CELL_COUNT: cell_count_r <= cfg_wdata[CNT_W-1:0];
        REG_MAIN_LIMIT: main_limit_r <= cfg_wdata[TGT_W-1:0];
        REG_HIGH_LIMIT: high_limit_r <= cfg_wdata[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rt_r  <= in_tdata[14:0];
      rv_r  <= in_tdata[29:15];
      mt_r  <= in_tdata[37:30];
      ht_r  <= in_tdata[45:38];
      act_r <= in_tuser;
    end
  end

  // temperature low-pass, shift 8
  always_comb begin
    if (tacc_r == '0 || !act_r) begin
      tacc_nxt = {1'b0, rt_r, 8'd0};
    end else begin
      tacc_nxt = tacc_r - {8'd0, tacc_r[TACC_W-1:8]} + {9'd0, rt_r};
    end
    ft_nxt = tacc_nxt[22:8];
  end

  // adaptive voltage low-pass
  logic signed [VACC_W-1:0] vsh4;
  logic signed [26:0]       vdiff;
  logic        [26:0]       vmag;
  logic        [1:0]        vstep;
  logic signed [VACC_W-1:0] vdecay;
  logic signed [27:0]       vbias;
  logic signed [27:0]       vbase;
  logic signed [27:0]       vterm;
  logic signed [27:0]       vsum;
  logic signed [21:0]       vout;

  always_comb begin
    vsh4  = vacc_r >>> 4;
    vdiff = {vsh4[VACC_W-1], vsh4} - $signed({12'd0, rv_r});
    vmag  = vdiff[26] ? 27'(-vdiff) : vdiff;
    if (vmag < 27'd32) begin
      vstep = 2'd0;
    end else if (vmag < 27'd64) begin
      vstep = 2'd1;
    end else if (vmag < 27'd128) begin
      vstep = 2'd2;
    end else begin
      vstep = 2'd3;
    end
    case (vstep)
      2'd0:    begin vdecay = vacc_r >>> 4; vbias = 28'sd16;  end
      2'd1:    begin vdecay = vacc_r >>> 3; vbias = 28'sd32;  end
      2'd2:    begin vdecay = vacc_r >>> 2; vbias = 28'sd64;  end
      default: begin vdecay = vacc_r >>> 1; vbias = 28'sd128; end
    endcase
    vbase = vdiff[26] ? ($signed({13'd0, rv_r}) - vbias)
                      : ($signed({13'd0, rv_r}) + vbias);
    vterm = vbase <<< vstep;
    vsum  = {{2{vacc_r[VACC_W-1]}}, vacc_r} - {{2{vdecay[VACC_W-1]}}, vdecay} + vterm;
    if (vacc_r == '0 || !act_r) begin
      vacc_nxt = $signed({7'd0, rv_r, 4'd0});
    end else begin
      vacc_nxt = vsum[VACC_W-1:0];
    end
    // saturate filtered value to the field range
    vout = vacc_nxt[VACC_W-1:4];
    if (vout[21]) begin
      fv_nxt = '0;
    end else if (vout[20:15] != 6'd0) begin
      fv_nxt = '1;
    end else begin
      fv_nxt = vout[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tacc_r <= '0;
      vacc_r <= '0;
    end else if (cmd.filt) begin
      tacc_r <= tacc_nxt;
      vacc_r <= vacc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.filt) begin
      ft_r <= ft_nxt;
      fv_r <= fv_nxt;
    end
  end

  // per-cell voltage
  logic [30:0] div3_prod;
  assign div3_prod = {16'd0, fv_r} * {15'd0, DIV3_MULT};

  always_comb begin
    case (cell_count_r)
      2'd2:    n_nxt = {1'b0, fv_r[VOLT_W-1:1]};
      2'd3:    n_nxt = {1'b0, div3_prod[30:DIV3_SHIFT]};
      default: n_nxt = fv_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      n_r <= n_nxt;
    end
  end

  // derating limits and beam clamps
  logic [TGT_W-1:0] vlim, tlim, design_lim, mcur, hcur;
  logic [VOLT_W-1:0] vlo_off, vmin_off;
  logic [TEMP_W-1:0] t_room;
  ldl_beam_t         mbeam, hbeam;

  always_comb begin
    vlo_off  = n_r - V_FLAT_LO;
    vmin_off = n_r - V_CELL_MIN;
    t_room   = T_MAX - ft_r;
    if (cell_count_r == 2'd0) begin
      vlim = '0;
    end else if (n_r >= V_CELL_MAX) begin
      vlim = '0;
    end else if (n_r >= V_FLAT_HI) begin
      vlim = DESIGN_FULL;
    end else if (n_r >= V_FLAT_LO) begin
      vlim = VLIM_MID + vlo_off[8:1];
    end else if (n_r >= V_CELL_MIN) begin
      vlim = VLIM_FLOOR + vmin_off[7:0];
    end else begin
      vlim = VLIM_FLOOR;
    end

    if (ft_r > T_MAX) begin
      tlim = '0;
    end else if (ft_r <= T_KNEE) begin
      tlim = DESIGN_FULL;
    end else begin
      tlim = t_room[7:0];
    end

    case (cell_count_r)
      2'd1, 2'd2: design_lim = DESIGN_FULL;
      2'd3:       design_lim = DESIGN_3CELL;
      default:    design_lim = '0;
    endcase
    mcur  = (main_limit_r > design_lim) ? design_lim : main_limit_r;
    hcur  = (high_limit_r > design_lim) ? design_lim : high_limit_r;
    mbeam = limit_beam(mt_r, mcur, vlim, tlim);
    hbeam = limit_beam(ht_r, hcur, vlim, tlim);
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {6'd0, ft_r, fv_r, hbeam.reason, mbeam.reason,
                     hbeam.drive, mbeam.drive};
    end
  end

  assign out_tdata = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/led_current_derating_limiter.sv =====
// top level of the led current derating limiter
//
//   channel  direction  payload
//   in_      slave      tdata: raw_temperature, raw_voltage, main_target, high_target
//                       tuser: filter_active
//   out_     master     tdata: main_drive, high_drive, main_reason, high_reason,
//                              filtered_voltage, filtered_temperature
//   cfg_     write      index 0 cell_count, 1 main_limit, 2 high_limit
//
// each beat passes in turn through capture, filter update, per-cell divide and limit.
// the divide by three is one 15x16 reciprocal multiply in the per-cell divide step.
// a new beat is taken while the last result still waits in the output register;
// the limit step stalls only while that register is full and out_tready is low.
// synchronous active-low reset clears the filters and control and resets the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module led_current_derating_limiter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ldl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ldl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // raw_temperature[14:0], raw_voltage[29:15], main_target[37:30],
  // high_target[45:38], zero pad[47:46]
  input  wire logic [ldl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // filter_active[0]
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // main_drive[7:0], high_drive[15:8], main_reason[17:16], high_reason[19:18],
  // filtered_voltage[34:20], filtered_temperature[49:35], zero pad[55:50]
  output logic [ldl_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import ldl_pkg::*;

  ldl_cmd_t cmd;

  // sequencing
  ldl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // arithmetic
  ldl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/derating_checker.sv =====
// checker for the derating limiter: mirrors its filters and limits, compares every result beat
`timescale 1ns / 1ps
module derating_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ldl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ldl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // raw_temperature, raw_voltage, main_target, high_target, zero pad
  input  logic [ldl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // filter_active
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // main_drive, high_drive, main_reason, high_reason, filtered_voltage,
  // filtered_temperature, zero pad
  input  logic [ldl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                               mismatches,
  output int                               outstanding
);
  import ldl_pkg::*;

  // one control tick, first field in the low bits
  typedef struct packed {
    logic [1:0]        pad;
    logic [TGT_W-1:0]  high_target;
    logic [TGT_W-1:0]  main_target;
    logic [VOLT_W-1:0] raw_voltage;
    logic [TEMP_W-1:0] raw_temperature;
  } tick_t;

  // one limited drive command
  typedef struct packed {
    logic [5:0]          pad;
    logic [TEMP_W-1:0]   filtered_temperature;
    logic [VOLT_W-1:0]   filtered_voltage;
    logic [REASON_W-1:0] high_reason;
    logic [REASON_W-1:0] main_reason;
    logic [TGT_W-1:0]    high_drive;
    logic [TGT_W-1:0]    main_drive;
  } drive_t;

  // mirrored registers and filter state
  logic [CNT_W-1:0]          cells;
  logic [TGT_W-1:0]          main_cap;
  logic [TGT_W-1:0]          high_cap;
  logic [TACC_W-1:0]         temp_acc;
  logic signed [VACC_W-1:0]  volt_acc;
  drive_t                    pending_drives[$];

  // lower one beam by current, voltage and temperature limits, last clamp names the cause
  function automatic void clamp_beam(input int target, input int cur, input int vlim,
                                     input int tlim, output logic [TGT_W-1:0] drive,
                                     output logic [REASON_W-1:0] reason);
    int level;
    level  = target;
    reason = RSN_NONE;
    if (level > cur) begin
      level  = cur;
      reason = RSN_CURRENT;
    end
    if (level > vlim) begin
      level  = vlim;
      reason = RSN_VOLTAGE;
    end
    if (level > tlim) begin
      level  = tlim;
      reason = RSN_TEMP;
    end
    drive = level[TGT_W-1:0];
  endfunction

  // advance both filters by one tick and derive the limited drives
  function automatic drive_t derate_tick(input tick_t t, input logic active);
    drive_t            r;
    logic [TACC_W-1:0] tnext;
    longint            acc;
    longint            raw_v;
    longint            diff;
    longint            mag;
    longint            sgn;
    longint            fv_wide;
    int                step;
    int                ft;
    int                fv;
    int                n;
    int                vlim;
    int                tlim;
    int                design_cap;
    int                main_cur;
    int                high_cur;
    r = '0;

    // temperature low-pass, shift 8, loads when empty or idle
    if (temp_acc == '0 || !active) begin
      tnext = TACC_W'(t.raw_temperature) << 8;
    end else begin
      tnext = temp_acc - (temp_acc >> 8) + TACC_W'(t.raw_temperature);
    end
    temp_acc = tnext;
    ft = int'(tnext[22:8]);

    // adaptive voltage low-pass, shift shrinks as the error grows
    raw_v = longint'(t.raw_voltage);
    acc   = longint'(volt_acc);
    if (acc == 0 || !active) begin
      acc = raw_v * 16;
    end else begin
      diff = (acc >>> 4) - raw_v;
      mag  = (diff < 0) ? -diff : diff;
      sgn  = (diff < 0) ? -1 : 1;
      step = 0;
      while (step < 3 && mag >= (longint'(32) << step)) step++;
      acc = acc - (acc >>> (4 - step));
      acc = acc + (raw_v + sgn * (longint'(16) << step)) * (longint'(1) << step);
    end
    volt_acc = acc[VACC_W-1:0];
    fv_wide  = longint'(volt_acc) >>> 4;
    fv = (fv_wide < 0) ? 0 : (fv_wide > 32767) ? 32767 : int'(fv_wide);

    // per-cell voltage derating
    if (cells == '0) begin
      vlim = 0;
    end else begin
      n = fv / int'(cells);
      if (n >= int'(V_CELL_MAX)) vlim = 0;
      else if (n >= int'(V_FLAT_HI)) vlim = 255;
      else if (n >= int'(V_FLAT_LO)) vlim = int'(VLIM_MID) + ((n - int'(V_FLAT_LO)) >> 1);
      else if (n >= int'(V_CELL_MIN)) vlim = int'(VLIM_FLOOR) + (n - int'(V_CELL_MIN));
      else vlim = int'(VLIM_FLOOR);
    end

    // thermal derating
    if (ft > int'(T_MAX)) tlim = 0;
    else if (ft <= int'(T_KNEE)) tlim = 255;
    else tlim = int'(T_MAX) - ft;

    // user limits capped by what the cell count allows
    case (cells)
      2'd1, 2'd2: design_cap = int'(DESIGN_FULL);
      2'd3:       design_cap = int'(DESIGN_3CELL);
      default:    design_cap = 0;
    endcase
    main_cur = (int'(main_cap) > design_cap) ? design_cap : int'(main_cap);
    high_cur = (int'(high_cap) > design_cap) ? design_cap : int'(high_cap);

    clamp_beam(int'(t.main_target), main_cur, vlim, tlim, r.main_drive, r.main_reason);
    clamp_beam(int'(t.high_target), high_cur, vlim, tlim, r.high_drive, r.high_reason);
    r.filtered_voltage     = fv[VOLT_W-1:0];
    r.filtered_temperature = ft[TEMP_W-1:0];
    return r;
  endfunction

  // count a mismatch, describe only the first few
  task automatic count_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) count_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // watch configuration writes and both channels
  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    if (!rst_n) begin
      cells    = CELL_COUNT_RESET;
      main_cap = LIMIT_RESET;
      high_cap = LIMIT_RESET;
      temp_acc = '0;
      volt_acc = '0;
      pending_drives.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CELL_COUNT: cells    = cfg_wdata[CNT_W-1:0];
          REG_MAIN_LIMIT: main_cap = cfg_wdata[TGT_W-1:0];
          REG_HIGH_LIMIT: high_cap = cfg_wdata[TGT_W-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_drives.size() == 0) begin
          count_mismatch($sformatf("result beat with nothing expected, tdata %h", out_tdata));
        end else begin
          want = pending_drives.pop_front();
          check_field("main_drive", want.main_drive, got.main_drive);
          check_field("high_drive", want.high_drive, got.high_drive);
          check_field("main_reason", want.main_reason, got.main_reason);
          check_field("high_reason", want.high_reason, got.high_reason);
          check_field("filtered_voltage", want.filtered_voltage, got.filtered_voltage);
          check_field("filtered_temperature", want.filtered_temperature,
                      got.filtered_temperature);
        end
      end

      // input beat gives one prediction
      if (in_tvalid && in_tready) pending_drives.push_back(derate_tick(in_tdata, in_tuser));
    end
    outstanding = pending_drives.size();
  end

endmodule

// ===== tb/testbench.sv =====
// testbench top: clock, reset, tick stimulus over several register settings, and the verdict
`timescale 1ns / 1ps
module testbench;
  import ldl_pkg::*;

  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLD_CYCLES     = 300;
  localparam int PHASES          = 8;
  localparam int TICKS_PER_PHASE = 235;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;

  int                      mismatches;
  int                      outstanding;
  int                      send_idle_pct;
  int                      recv_stall_pct;
  bit                      hold_request;
  logic [CNT_W-1:0]        cells_now;
  int                      temp_center;
  int                      quiet;

  led_current_derating_limiter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  derating_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles without any beat
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // offer one tick, with random gaps first, and wait until it is accepted
  task automatic send_tick(input logic [TEMP_W-1:0] rt, input logic [VOLT_W-1:0] rv,
                           input logic [TGT_W-1:0] mt, input logic [TGT_W-1:0] ht,
                           input logic fa);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, ht, mt, rv, rt};
    in_tuser  <= fa;
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly plausible ticks around the derating knees, some noise and brown-outs
  task automatic random_tick();
    int                pick;
    int                cells_eff;
    int                per_cell;
    logic [TEMP_W-1:0] rt;
    logic [VOLT_W-1:0] rv;
    logic [TGT_W-1:0]  mt;
    logic [TGT_W-1:0]  ht;
    logic              fa;
    pick      = $urandom_range(0, 99);
    cells_eff = (cells_now == '0) ? $urandom_range(1, 3) : int'(cells_now);
    mt = 8'($urandom);
    ht = 8'($urandom);
    if ($urandom_range(0, 7) == 0) mt = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    if ($urandom_range(0, 7) == 0) ht = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    fa = ($urandom_range(0, 7) != 0);
    // slow drift of the operating temperature across both knees
    if ($urandom_range(0, 149) == 0) temp_center = $urandom_range(5000, 5900);
    rt = 15'(temp_center - 100 + $urandom_range(0, 200));
    if (pick < 82) begin
      per_cell = $urandom_range(2950, 4500);
      rv = 15'(per_cell * cells_eff + $urandom_range(0, 7));
    end else if (pick < 90) begin
      // brown-out, drives the voltage filter below zero
      rv = 15'($urandom_range(0, 48));
    end else if (pick < 96) begin
      rt = 15'($urandom);
      rv = 15'($urandom);
      fa = 1'($urandom);
    end else begin
      rt = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
      rv = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
    end
    send_tick(rt, rv, mt, ht, fa);
  endtask

  // drop valid and let the block drain
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic configure(input logic [7:0] cells_byte, input logic [7:0] main_lim,
                           input logic [7:0] high_lim);
    write_reg(REG_CELL_COUNT, cells_byte);
    write_reg(REG_MAIN_LIMIT, main_lim);
    write_reg(REG_HIGH_LIMIT, high_lim);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cells_now = cells_byte[CNT_W-1:0];
  endtask

  // main sequence
  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    cells_now      = CELL_COUNT_RESET;
    temp_center    = 5400;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // new register setting while the block is idle
      if (phase > 0) begin
        settle();
        case (phase)
          1: configure(8'd3, 8'd255, 8'd255);
          2: configure(8'd0, 8'd0, 8'd255);
          3: configure(8'd2, 8'($urandom), 8'd0);
          4: begin
            write_reg(REG_SPARE, 8'($urandom));
            configure(8'd1, 8'd255, 8'($urandom));
          end
          5: configure(8'hff, 8'($urandom), 8'($urandom));
          6: configure({6'($urandom), 2'd2}, 8'($urandom), 8'($urandom));
          default: configure(8'd1, 8'($urandom_range(150, 255)), 8'($urandom_range(150, 255)));
        endcase
      end

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // sink holds off while the source keeps offering
      if (phase == 4) hold_request = 1'b1;

      if (phase == 0) begin
        // field extremes, then reload with filtering on
        send_tick(15'h0000, 15'h0000, 8'd0, 8'd0, 1'b0);
        send_tick(15'h7fff, 15'h7fff, 8'd255, 8'd255, 1'b1);
        send_tick(15'h7fff, 15'h7fff, 8'd255, 8'd255, 1'b1);
        // voltage derating knees, filters loading directly
        send_tick(15'd4000, 15'd3096, 8'd255, 8'd128, 1'b0);
        send_tick(15'd4000, 15'd3097, 8'd255, 8'd128, 1'b0);
        send_tick(15'd4000, 15'd3222, 8'd255, 8'd128, 1'b0);
        send_tick(15'd4000, 15'd3223, 8'd255, 8'd128, 1'b0);
        send_tick(15'd4000, 15'd3476, 8'd255, 8'd128, 1'b0);
        send_tick(15'd4000, 15'd3477, 8'd255, 8'd128, 1'b0);
        send_tick(15'd4000, 15'd4351, 8'd255, 8'd128, 1'b0);
        send_tick(15'd4000, 15'd4352, 8'd255, 8'd128, 1'b0);
        // thermal derating knees
        send_tick(15'd5312, 15'd3477, 8'd255, 8'd40, 1'b0);
        send_tick(15'd5313, 15'd3477, 8'd255, 8'd40, 1'b0);
        send_tick(15'd5567, 15'd3477, 8'd255, 8'd40, 1'b0);
        send_tick(15'd5568, 15'd3477, 8'd255, 8'd40, 1'b0);
        send_tick(15'd5569, 15'd3477, 8'd255, 8'd40, 1'b0);
        // target right at the current limit
        send_tick(15'd4000, 15'd3477, 8'd216, 8'd217, 1'b0);
        // tiny supply with filtering on, voltage filter goes negative
        send_tick(15'd4000, 15'd1, 8'd100, 8'd100, 1'b0);
        send_tick(15'd4000, 15'd5, 8'd100, 8'd100, 1'b1);
        send_tick(15'd4000, 15'd10, 8'd100, 8'd100, 1'b1);
        send_tick(15'd4000, 15'd3, 8'd100, 8'd100, 1'b1);
        send_tick(15'd4000, 15'd0, 8'd100, 8'd100, 1'b1);
      end

      for (int k = 0; k < TICKS_PER_PHASE; k++) random_tick();
    end

    // drain and decide
    settle();
    repeat (12) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
